// ===== design/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

  localparam int COORD_W = 8;

  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_POS   = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_RETURN    = 8'h0D;

  localparam logic [2:0] REG_COLOUR = 3'd0;
  localparam logic [2:0] REG_LEFT   = 3'd1;
  localparam logic [2:0] REG_TOP    = 3'd2;
  localparam logic [2:0] REG_WIDTH  = 3'd3;
  localparam logic [2:0] REG_HEIGHT = 3'd4;

  localparam logic [7:0] RST_COLOUR = 8'h0F;
  localparam logic [6:0] RST_LEFT   = 7'd0;
  localparam logic [4:0] RST_TOP    = 5'd0;
  localparam logic [6:0] RST_WIDTH  = 7'd80;
  localparam logic [4:0] RST_HEIGHT = 5'd25;

  typedef struct packed {
    logic [7:0] draw_colour;
    logic [6:0] window_left;
    logic [4:0] window_top;
    logic [6:0] window_width;
    logic [4:0] window_height;
  } tcw_cfg_t;

  typedef struct packed {
    logic capture;
    logic clamp;
    logic calc_addr;
    logic exec;
    logic rd_capture;
    logic walk_init;
    logic walk_step;
    logic scr_rd;
    logic scr_wr;
    logic clr_wr;
    logic init_step;
    logic out_load;
  } tcw_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       will_scroll;
    logic       walk_last;
    logic       init_last;
    logic       out_free;
  } tcw_stat_t;

endpackage

`default_nettype wire

// ===== design/tcw_regs.sv =====
// ----------------------------------------------------------------------------
// tcw_regs
// Configuration register file behind the register bus port.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_regs (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [4:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic      [31:0]      prdata,
  output logic                  pready,
  output tcw_pkg::tcw_cfg_t     cfg
);
  import tcw_pkg::*;

  logic       wr;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite & pready;
  assign idx    = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.draw_colour   <= RST_COLOUR;
      cfg.window_left   <= RST_LEFT;
      cfg.window_top    <= RST_TOP;
      cfg.window_width  <= RST_WIDTH;
      cfg.window_height <= RST_HEIGHT;
    end else if (wr) begin
      unique case (idx)
        REG_COLOUR: cfg.draw_colour   <= pwdata[7:0];
        REG_LEFT:   cfg.window_left   <= pwdata[6:0];
        REG_TOP:    cfg.window_top    <= pwdata[4:0];
        REG_WIDTH:  cfg.window_width  <= pwdata[6:0];
        REG_HEIGHT: cfg.window_height <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_COLOUR: prdata = {24'd0, cfg.draw_colour};
      REG_LEFT:   prdata = {25'd0, cfg.window_left};
      REG_TOP:    prdata = {27'd0, cfg.window_top};
      REG_WIDTH:  prdata = {25'd0, cfg.window_width};
      REG_HEIGHT: prdata = {27'd0, cfg.window_height};
      default:    prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/tcw_dp.sv =====
// ----------------------------------------------------------------------------
// tcw_dp
// Datapath: window settle, cursor, address walker, screen store, result reg.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_dp #(
  parameter int SCREEN_COLUMNS = 80,
  parameter int SCREEN_ROWS    = 25
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  tcw_pkg::tcw_cfg_t      cfg,
  input  wire logic [23:0]       s_tdata,
  input  wire logic [1:0]        s_tuser,
  input  tcw_pkg::tcw_cmd_t      cmd,
  output tcw_pkg::tcw_stat_t     stat,
  input  wire logic              m_tready,
  output logic                   m_tvalid,
  output logic [31:0]            m_tdata
);
  import tcw_pkg::*;

  localparam int DEPTH = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [8:0]    SC9   = 9'(SCREEN_COLUMNS);
  localparam logic [8:0]    SR9   = 9'(SCREEN_ROWS);
  localparam logic [AW-1:0] SC_A  = AW'(SCREEN_COLUMNS);
  localparam logic [AW-1:0] LAST_A = AW'(DEPTH - 1);

  logic [1:0]         op;
  logic [7:0]         in_ch;
  logic [6:0]         in_col;
  logic [4:0]         in_row;

  logic [COORD_W-1:0] left_sat, top_sat, w_min, h_min, w_fit, h_fit;
  logic [8:0]         w_room, h_room;
  logic [COORD_W-1:0] eff_left, eff_top, eff_w, eff_h;
  logic [COORD_W-1:0] cur_col, cur_row;
  logic [COORD_W-1:0] wx, wy;
  logic [AW-1:0]      win_base, addr, row_start, addr_calc, raddr, waddr;
  logic [COORD_W-1:0] m_row, m_col;
  logic [AW-1:0]      m_base;

  logic [15:0]        mem [DEPTH];
  logic [15:0]        rdata, wdata;
  logic               we;

  logic [7:0]         rd_ch, rd_colour;
  logic               scrolled;

  logic w_last, h_last, col_last, row_last;
  logic is_bs, bs_zero, put_nl, put_cr, put_char, adv, row_inc, put_wr, in_bounds;

  // effective window from the registers
  always_comb begin
    left_sat = ({2'b00, cfg.window_left} < SC9) ? {1'b0, cfg.window_left}
                                                : 8'(SCREEN_COLUMNS - 1);
    top_sat  = ({4'b0000, cfg.window_top} < SR9) ? {3'b000, cfg.window_top}
                                                 : 8'(SCREEN_ROWS - 1);
    w_min    = (cfg.window_width == 7'd0) ? 8'd1 : {1'b0, cfg.window_width};
    h_min    = (cfg.window_height == 5'd0) ? 8'd1 : {3'b000, cfg.window_height};
    w_room   = SC9 - {1'b0, left_sat};
    h_room   = SR9 - {1'b0, top_sat};
    w_fit    = ({1'b0, w_min} > w_room) ? w_room[7:0] : w_min;
    h_fit    = ({1'b0, h_min} > h_room) ? h_room[7:0] : h_min;
  end

  always_ff @(posedge clk) begin
    eff_left <= left_sat;
    eff_top  <= top_sat;
    eff_w    <= w_fit;
    eff_h    <= h_fit;
    win_base <= AW'(32'(eff_top) * 32'(SCREEN_COLUMNS) + 32'(eff_left));
  end

  // put decode
  always_comb begin
    w_last    = (wx == eff_w - 8'd1);
    h_last    = (wy == eff_h - 8'd1);
    col_last  = (cur_col == eff_w - 8'd1);
    row_last  = (cur_row == eff_h - 8'd1);
    is_bs     = (in_ch == CH_BACKSPACE);
    bs_zero   = is_bs && (cur_col == 8'd0);
    put_nl    = (in_ch == CH_NEWLINE);
    put_cr    = (in_ch == CH_RETURN);
    put_char  = !is_bs && !put_nl && !put_cr;
    adv       = put_char && (in_ch != 8'd0);
    row_inc   = put_nl || (adv && col_last);
    put_wr    = cmd.exec && (op == OP_PUT) && (is_bs ? !bs_zero : put_char);
    in_bounds = ({2'b00, in_col} < SC9) && ({4'b0000, in_row} < SR9);
  end

  always_comb begin
    m_row     = (op == OP_READ) ? {3'b000, in_row} : cur_row;
    m_col     = (op == OP_READ) ? {1'b0, in_col} : cur_col;
    m_base    = (op == OP_READ) ? '0 : win_base;
    addr_calc = AW'(32'(m_base) + 32'(m_row) * 32'(SCREEN_COLUMNS) + 32'(m_col));
  end

  // store ports
  always_comb begin
    raddr = (cmd.scr_rd && !h_last) ? addr + SC_A : addr;
    we    = 1'b0;
    waddr = addr;
    wdata = 16'd0;
    priority if (cmd.init_step) begin
      we = 1'b1;
    end else if (put_wr) begin
      we    = 1'b1;
      waddr = is_bs ? addr - AW'(1) : addr;
      wdata = {cfg.draw_colour, is_bs ? 8'd0 : in_ch};
    end else if (cmd.scr_wr) begin
      we    = 1'b1;
      wdata = h_last ? {rdata[15:8], 8'd0} : rdata;
    end else if (cmd.clr_wr) begin
      we    = 1'b1;
      wdata = {cfg.draw_colour, 8'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // input item and read results
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op        <= s_tuser;
      in_ch     <= s_tdata[7:0];
      in_col    <= s_tdata[14:8];
      in_row    <= s_tdata[19:15];
      rd_ch     <= 8'd0;
      rd_colour <= 8'd0;
      scrolled  <= 1'b0;
    end else begin
      if (cmd.rd_capture && in_bounds) begin
        rd_ch     <= rdata[7:0];
        rd_colour <= rdata[15:8];
      end
      if (cmd.exec && (op == OP_PUT)) begin
        scrolled <= row_inc && row_last;
      end
    end
  end

  // walker
  always_ff @(posedge clk) begin
    if (cmd.walk_init) begin
      wx        <= 8'd0;
      wy        <= 8'd0;
      row_start <= win_base;
    end else if (cmd.walk_step && w_last) begin
      wx        <= 8'd0;
      wy        <= wy + 8'd1;
      row_start <= row_start + SC_A;
    end else if (cmd.walk_step) begin
      wx <= wx + 8'd1;
    end
  end

  // control state: cursor, address, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col  <= 8'd0;
      cur_row  <= 8'd0;
      addr     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.clamp) begin
        if (cur_col >= eff_w) cur_col <= eff_w - 8'd1;
        if (cur_row >= eff_h) cur_row <= eff_h - 8'd1;
      end else if (cmd.exec) begin
        unique case (op)
          OP_PUT: begin
            if (is_bs) begin
              if (!bs_zero) cur_col <= cur_col - 8'd1;
            end else if (put_nl || put_cr) begin
              cur_col <= 8'd0;
              if (put_nl && !row_last) cur_row <= cur_row + 8'd1;
            end else if (adv) begin
              if (col_last) begin
                cur_col <= 8'd0;
                if (!row_last) cur_row <= cur_row + 8'd1;
              end else begin
                cur_col <= cur_col + 8'd1;
              end
            end
          end
          OP_POS: begin
            cur_col <= ({1'b0, in_col} < eff_w) ? {1'b0, in_col} : eff_w - 8'd1;
            cur_row <= ({3'b000, in_row} < eff_h) ? {3'b000, in_row} : eff_h - 8'd1;
          end
          default: ;
        endcase
      end

      priority if (cmd.walk_init) begin
        addr <= win_base;
      end else if (cmd.walk_step) begin
        addr <= w_last ? row_start + SC_A : addr + AW'(1);
      end else if (cmd.init_step) begin
        addr <= addr + AW'(1);
      end else if (cmd.calc_addr) begin
        addr <= addr_calc;
      end

      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= {3'b000, scrolled, rd_colour, rd_ch,
                  5'(eff_top + cur_row), 7'(eff_left + cur_col)};
    end
  end

  always_comb begin
    stat.op          = op;
    stat.will_scroll = (op == OP_PUT) && row_inc && row_last;
    stat.walk_last   = w_last && h_last;
    stat.init_last   = (addr == LAST_A);
    stat.out_free    = !m_tvalid || m_tready;
  end

endmodule

`default_nettype wire

// ===== design/tcw_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcw_ctrl
// Controller state machine sequencing each operation through the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           s_tvalid,
  output logic                s_tready,
  input  tcw_pkg::tcw_stat_t  stat,
  output tcw_pkg::tcw_cmd_t   cmd
);
  import tcw_pkg::*;

  localparam logic [3:0] ST_INIT   = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_PREP   = 4'd2;
  localparam logic [3:0] ST_ADDR   = 4'd3;
  localparam logic [3:0] ST_EXEC   = 4'd4;
  localparam logic [3:0] ST_RDWAIT = 4'd5;
  localparam logic [3:0] ST_SCR_RD = 4'd6;
  localparam logic [3:0] ST_SCR_WR = 4'd7;
  localparam logic [3:0] ST_CLR    = 4'd8;
  localparam logic [3:0] ST_FINISH = 4'd9;

  logic [3:0] state, state_next;

  assign s_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_INIT: begin
        cmd.init_step = 1'b1;
        if (stat.init_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.clamp  = 1'b1;
        state_next = ST_ADDR;
      end
      ST_ADDR: begin
        cmd.calc_addr = 1'b1;
        state_next    = ST_EXEC;
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        unique case (stat.op)
          OP_PUT: begin
            if (stat.will_scroll) begin
              cmd.walk_init = 1'b1;
              state_next    = ST_SCR_RD;
            end else begin
              state_next = ST_FINISH;
            end
          end
          OP_READ: state_next = ST_RDWAIT;
          OP_POS:  state_next = ST_FINISH;
          default: begin
            cmd.walk_init = 1'b1;
            state_next    = ST_CLR;
          end
        endcase
      end
      ST_RDWAIT: begin
        cmd.rd_capture = 1'b1;
        state_next     = ST_FINISH;
      end
      ST_SCR_RD: begin
        cmd.scr_rd = 1'b1;
        state_next = ST_SCR_WR;
      end
      ST_SCR_WR: begin
        cmd.scr_wr    = 1'b1;
        cmd.walk_step = 1'b1;
        state_next    = stat.walk_last ? ST_FINISH : ST_SCR_RD;
      end
      ST_CLR: begin
        cmd.clr_wr    = 1'b1;
        cmd.walk_step = 1'b1;
        if (stat.walk_last) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/text_console_writer_top.sv =====
// ----------------------------------------------------------------------------
// text_console_writer_top
// Text console over a character and colour screen store.
//
// channel   dir  transaction
// s_*       in   operation in tuser, character/column/row in tdata
// m_*       out  cursor position, read cell, scroll flag in tdata
// p*        in   register writes and reads, always ready
//
// put, position: accept, then PREP, ADDR, EXEC, FINISH; read adds RDWAIT
// scroll reads and then writes each window cell (one store port each for read
// and write); clear writes each window cell in turn
// after reset the whole store is cleared one cell a cycle with s_tready low;
// one transaction is in work at a time
// a finished result waits in the output register while the next is accepted
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer_top #(
  parameter int SCREEN_COLUMNS = 80,
  parameter int SCREEN_ROWS    = 25
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // character, column, row
  input  wire logic [1:0]  s_tuser,   // operation
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // cursor_screen_column, cursor_screen_row,
                                      // cell_character, cell_colour, scrolled
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import tcw_pkg::*;

  tcw_cfg_t  cfg;
  tcw_cmd_t  cmd;
  tcw_stat_t stat;

  tcw_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tcw_dp #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_ROWS    (SCREEN_ROWS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cmd      (cmd),
    .stat     (stat),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata)
  );

`ifndef SYNTHESIS
  // one transaction in work at a time
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while a transaction is in work");

  // a scrolled put never carries read data
  a_scroll_no_cell: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[28] |-> m_tdata[27:12] == 16'd0)
    else $error("scrolled result carries cell data");

  // store clearing holds off input after reset
  a_init_blocks: assert property (@(posedge clk)
    $fell(rst) |-> !s_tready)
    else $error("input ready during store clearing");

  // a result is loaded only when the output register is free
  a_out_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> stat.out_free)
    else $error("result loaded over a pending one");
`endif

endmodule

`default_nettype wire
